>>> hdl/mptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Field widths, status and register codes, FSM states and shared structs.
// ----------------------------------------------------------------------------
package mptw_pkg;

    localparam int VPAGE_W  = 45;
    localparam int FRAME_NW = 52;
    localparam int ENTRY_W  = FRAME_NW + 1;
    localparam int IDX_W    = 9;
    localparam int MAX_LVLS = 6;
    localparam int ROOT_W   = 6;
    localparam int FREE_W   = 7;
    localparam int CFG_W    = 7;

    // Config register indexes
    localparam logic CFG_ROOT_FRAME = 1'b0;
    localparam logic CFG_FIRST_FREE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_NOMAP  = 2'd1;
    localparam logic [1:0] STATUS_OOB    = 2'd2;
    localparam logic [1:0] STATUS_NOFREE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVAL,
        ST_FINISH
    } walk_state_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

    typedef struct packed {
        logic [FRAME_NW-1:0] found_frame;
        logic [1:0]          status;
    } walk_res_t;

endpackage

>>> hdl/mptw_if.sv
// ----------------------------------------------------------------------------
// Page table walker channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface mptw_req_if;
    import mptw_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [VPAGE_W-1:0]  virtual_page;
    logic [FRAME_NW-1:0] target_frame;
    logic               unmap;

    modport source (output valid, mode, virtual_page, target_frame, unmap, input ready);
    modport sink   (input valid, mode, virtual_page, target_frame, unmap, output ready);
endinterface

interface mptw_rsp_if;
    import mptw_pkg::*;

    logic                valid;
    logic                ready;
    logic [FRAME_NW-1:0] found_frame;
    logic [1:0]          status;

    modport source (output valid, found_frame, status, input ready);
    modport sink   (input valid, found_frame, status, output ready);
endinterface

>>> hdl/mptw_store.sv
// ----------------------------------------------------------------------------
// Frame store
// Single-port synchronous table memory with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module mptw_store #(
    parameter int FRAMES = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  mptw_pkg::mem_cmd_t                         cmd,
    input  logic [$clog2(FRAMES)+mptw_pkg::IDX_W-1:0]  addr,
    input  logic [mptw_pkg::ENTRY_W-1:0]               wdata,
    output logic [mptw_pkg::ENTRY_W-1:0]               rdata,
    output logic                                       clearing
);
    import mptw_pkg::*;

    localparam int ADDR_W = $clog2(FRAMES) + IDX_W;
    localparam int DEPTH  = FRAMES * (2 ** IDX_W);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               clearing_reg, clearing_next;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    // Zero the store during the sweep, otherwise take the walker's write
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

>>> hdl/mptw_walker.sv
// ----------------------------------------------------------------------------
// Walk sequencer
// Steps one request through the table levels, allocating tables on update.
// ----------------------------------------------------------------------------
module mptw_walker #(
    parameter int FRAMES = 64,
    parameter int LEVELS = 5
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    mptw_req_if.sink                                   req,
    input  logic [mptw_pkg::ROOT_W-1:0]                root_frame,
    input  logic                                       free_load,
    input  logic [mptw_pkg::FREE_W-1:0]                free_value,
    input  logic                                       clearing,
    output mptw_pkg::mem_cmd_t                         mem_cmd,
    output logic [$clog2(FRAMES)+mptw_pkg::IDX_W-1:0]  mem_addr,
    output logic [mptw_pkg::ENTRY_W-1:0]               mem_wdata,
    input  logic [mptw_pkg::ENTRY_W-1:0]               mem_rdata,
    output logic                                       res_valid,
    input  logic                                       res_ready,
    output mptw_pkg::walk_res_t                        res
);
    import mptw_pkg::*;

    localparam int FRAME_W = $clog2(FRAMES);
    localparam int FB_W    = $clog2(FRAMES + 1);
    localparam int NF_W    = (FB_W > FREE_W) ? FB_W : FREE_W;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int VEXT_W  = IDX_W * MAX_LVLS;

    walk_state_t         state_reg, state_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [FRAME_W-1:0]  table_reg, table_next;
    logic                oob_reg, oob_next;
    logic [NF_W-1:0]     next_free_reg, next_free_next;
    logic                mode_reg, mode_next;
    logic                unmap_reg, unmap_next;
    logic [VPAGE_W-1:0]  vpage_reg, vpage_next;
    logic [FRAME_NW-1:0] target_reg, target_next;
    walk_res_t           res_reg, res_next;

    logic [VEXT_W-1:0]   vpage_ext;
    logic [IDX_W-1:0]    lvl_idx [LEVELS];
    logic                leaf;
    logic                entry_valid;
    logic [FRAME_NW-1:0] entry_frame;
    logic                alloc_ok;
    logic                accept;

    assign vpage_ext = {{(VEXT_W - VPAGE_W){1'b0}}, vpage_reg};

    // Level k takes the k-th 9-bit field counted from the top
    always_comb
    begin
        for (int k = 0; k < LEVELS; k++)
        begin
            lvl_idx[k] = vpage_ext[IDX_W * (LEVELS - 1 - k) +: IDX_W];
        end
    end

    assign leaf        = (lvl_reg == LVL_W'(LEVELS - 1));
    assign entry_valid = mem_rdata[0];
    assign entry_frame = mem_rdata[ENTRY_W-1:1];
    assign alloc_ok    = (next_free_reg < NF_W'(FRAMES));
    assign accept      = req.valid && req.ready;
    assign mem_addr    = {table_reg, lvl_idx[lvl_reg]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (oob_reg || (leaf && mode_reg))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (leaf)
                begin
                    state_next = ST_FINISH;
                end
                else if (entry_valid)
                begin
                    state_next = ST_LOOKUP;
                end
                else if (!mode_reg || unmap_reg || !alloc_ok)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory commands
    always_comb
    begin
        lvl_next    = lvl_reg;
        table_next  = table_reg;
        oob_next    = oob_reg;
        mode_next   = mode_reg;
        unmap_next  = unmap_reg;
        vpage_next  = vpage_reg;
        target_next = target_reg;
        res_next    = res_reg;
        next_free_next = next_free_reg;
        mem_cmd     = '0;
        mem_wdata   = '0;
        req.ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = !clearing;
                if (accept)
                begin
                    mode_next   = req.mode;
                    unmap_next  = req.unmap;
                    vpage_next  = req.virtual_page;
                    target_next = req.target_frame;
                    lvl_next    = '0;
                    table_next  = FRAME_W'(root_frame);
                    oob_next    = ({{(32 - ROOT_W){1'b0}}, root_frame} >= 32'(FRAMES));
                end
            end
            ST_LOOKUP:
            begin
                res_next.found_frame = '0;
                if (oob_reg)
                begin
                    res_next.status = STATUS_OOB;
                end
                else if (leaf && mode_reg)
                begin
                    // Leaf update is a blind write: set or clear the entry
                    mem_cmd.wr      = 1'b1;
                    mem_wdata       = unmap_reg ? '0 : {target_reg, 1'b1};
                    res_next.status = STATUS_DONE;
                end
                else
                begin
                    mem_cmd.rd = 1'b1;
                end
            end
            ST_EVAL:
            begin
                if (leaf)
                begin
                    if (entry_valid)
                    begin
                        res_next.found_frame = entry_frame;
                        res_next.status      = STATUS_DONE;
                    end
                    else
                    begin
                        res_next.status = STATUS_NOMAP;
                    end
                end
                else if (entry_valid)
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    table_next = FRAME_W'(entry_frame);
                    oob_next   = (entry_frame >= FRAME_NW'(FRAMES));
                end
                else if (!mode_reg || unmap_reg)
                begin
                    res_next.status = STATUS_NOMAP;
                end
                else if (!alloc_ok)
                begin
                    res_next.status = STATUS_NOFREE;
                end
                else
                begin
                    // Hand out the next free frame and link it in
                    mem_cmd.wr     = 1'b1;
                    mem_wdata      = {FRAME_NW'(next_free_reg), 1'b1};
                    next_free_next = next_free_reg + NF_W'(1);
                    lvl_next       = lvl_reg + LVL_W'(1);
                    table_next     = FRAME_W'(next_free_reg);
                    oob_next       = 1'b0;
                end
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase

        if (free_load)
        begin
            next_free_next = NF_W'(free_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_free_reg <= NF_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        table_reg  <= table_next;
        oob_reg    <= oob_next;
        mode_reg   <= mode_next;
        unmap_reg  <= unmap_next;
        vpage_reg  <= vpage_next;
        target_reg <= target_next;
        res_reg    <= res_next;
    end

    assign res_valid = (state_reg == ST_FINISH);
    assign res       = res_reg;

endmodule

>>> hdl/multilevel_page_table_walker.sv
// ----------------------------------------------------------------------------
// Multilevel page table walker
// Five-level radix page table held in an on-chip frame store.
// ----------------------------------------------------------------------------
// Each request item is a query or an update of one virtual page. The walker
// reads one table entry per level from a single-port frame store with a
// registered read; each level issues its read in a lookup state and uses the
// entry in an evaluate state, an update writes its leaf from the lookup state,
// and the next request is taken only after the finish state. Updates allocate
// missing intermediate tables from a bump allocator that is reloaded whenever
// first_free_frame is written. After reset the store is zeroed one entry per
// cycle, FRAMES*512 entries (32768 at the default), and no request is taken
// until that sweep is done; configuration writes are taken throughout. The
// response goes into an output register, so a new request can start while a
// result waits there.
// Status: 0 done, 1 no mapping, 2 table frame outside store, 3 out of frames.
// ----------------------------------------------------------------------------
module multilevel_page_table_walker #(
    parameter int FRAMES = 64,
    parameter int LEVELS = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mptw_req_if.sink                    req,
    mptw_rsp_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [mptw_pkg::CFG_W-1:0]  cfg_data
);
    import mptw_pkg::*;

    localparam int ADDR_W = $clog2(FRAMES) + IDX_W;

    logic [ROOT_W-1:0]   root_frame_reg, root_frame_next;
    logic                out_valid_reg, out_valid_next;
    walk_res_t           out_reg, out_next;

    mem_cmd_t            mem_cmd;
    logic [ADDR_W-1:0]   mem_addr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ENTRY_W-1:0]  mem_rdata;
    logic                clearing;
    logic                free_load;
    logic                res_valid;
    logic                res_ready;
    walk_res_t           res;

    // Config decode: root pointer is held here, allocator reload goes down
    assign free_load = cfg_we && (cfg_index == CFG_FIRST_FREE);

    always_comb
    begin
        root_frame_next = root_frame_reg;
        if (cfg_we && (cfg_index == CFG_ROOT_FRAME))
        begin
            root_frame_next = cfg_data[ROOT_W-1:0];
        end
    end

    // Output register: take a result when empty or being drained this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            root_frame_reg <= root_frame_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found_frame = out_reg.found_frame;
    assign rsp.status      = out_reg.status;

    mptw_walker #(
        .FRAMES (FRAMES),
        .LEVELS (LEVELS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .root_frame (root_frame_reg),
        .free_load  (free_load),
        .free_value (cfg_data[FREE_W-1:0]),
        .clearing   (clearing),
        .mem_cmd    (mem_cmd),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    mptw_store #(
        .FRAMES (FRAMES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mem_cmd),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

endmodule

>>> hdl/mptw_checker.sv
// ----------------------------------------------------------------------------
// Page table walker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mptw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mptw_pkg::FRAME_NW-1:0] out_found_frame,
    input logic [1:0]                    out_status
);
    import mptw_pkg::*;

    // A failed walk never reports a frame
    a_no_frame_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status != STATUS_DONE)) |-> (out_found_frame == '0))
        else $error("frame reported with a failing status");

    // One walk at a time: no new item right after one is taken
    a_one_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a walk is running");

    // An item taken now cannot already be answered next cycle
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("response appeared too early");

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_found_frame) && $stable(out_status)))
        else $error("stalled response changed");

endmodule

bind multilevel_page_table_walker mptw_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_found_frame (rsp.found_frame),
    .out_status      (rsp.status)
);

>>> tb/sv/page_walk_checker.sv
// ----------------------------------------------------------------------------
// Page table walker checker
// Watches the request, response and register ports, runs a walk model of its
// own over a private copy of the frame store and compares every response.
// ----------------------------------------------------------------------------
module page_walk_checker #(
    parameter int FRAMES = 64,
    parameter int LEVELS = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mptw_req_if                        req,
    mptw_rsp_if                        rsp,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [mptw_pkg::CFG_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         open_items
);
    timeunit 1ns;
    timeprecision 1ps;

    import mptw_pkg::*;

    localparam int SLOTS = 1 << IDX_W;

    logic [ENTRY_W-1:0] frame_image [FRAMES*SLOTS];
    logic [ROOT_W-1:0]  root_reg;
    int unsigned        next_free;
    walk_res_t          expected_q [$];

    function automatic int level_index(input logic [VPAGE_W-1:0] vp, input int lvl);
        return int'(vp[IDX_W*(LEVELS-1-lvl) +: IDX_W]);
    endfunction

    // Walk the private store exactly as the block does; updates modify it.
    function automatic walk_res_t walk_table(
        input logic                is_update,
        input logic [VPAGE_W-1:0]  vp,
        input logic [FRAME_NW-1:0] tgt,
        input logic                drop_leaf
    );
        walk_res_t          r;
        logic [FRAME_NW-1:0] tbl;
        logic [ENTRY_W-1:0]  ent;
        int                  slot;
        r.found_frame = '0;
        r.status      = STATUS_DONE;
        tbl = FRAME_NW'(root_reg);
        for (int lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            if (tbl >= FRAMES)
            begin
                r.status = STATUS_OOB;
                return r;
            end
            slot = int'(tbl) * SLOTS + level_index(vp, lvl);
            ent  = frame_image[slot];
            if (!ent[0])
            begin
                if (!is_update || drop_leaf)
                begin
                    r.status = STATUS_NOMAP;
                    return r;
                end
                if (next_free >= FRAMES)
                begin
                    r.status = STATUS_NOFREE;
                    return r;
                end
                // fresh frames are not cleared, whatever they held is reused
                ent = {FRAME_NW'(next_free), 1'b1};
                frame_image[slot] = ent;
                next_free++;
            end
            tbl = ent[ENTRY_W-1:1];
        end
        if (tbl >= FRAMES)
            r.status = STATUS_OOB;
        else
        begin
            slot = int'(tbl) * SLOTS + level_index(vp, LEVELS - 1);
            if (!is_update)
            begin
                if (!frame_image[slot][0])
                    r.status = STATUS_NOMAP;
                else
                    r.found_frame = frame_image[slot][ENTRY_W-1:1];
            end
            else if (drop_leaf)
                frame_image[slot] = '0;
            else
                frame_image[slot] = {tgt, 1'b1};
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        walk_res_t want;
        logic      took_req;
        logic      gave_rsp;
        if (!rst_n)
        begin
            foreach (frame_image[i])
                frame_image[i] = '0;
            root_reg  = '0;
            next_free = 1;
            expected_q.delete();
            mismatch_count <= 0;
            open_items     <= 0;
        end
        else
        begin
            took_req = req.valid && req.ready;
            gave_rsp = rsp.valid && rsp.ready;
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROOT_FRAME)
                    root_reg = cfg_data[ROOT_W-1:0];
                else
                    next_free = int'(cfg_data[FREE_W-1:0]);
            end
            // pop before push so a stray response never eats a fresh item
            if (gave_rsp)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: response with nothing expected: frame %h status %0d",
                             $time, rsp.found_frame, rsp.status);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.found_frame !== want.found_frame
                        || rsp.status !== want.status)
                    begin
                        if (rsp.found_frame !== want.found_frame)
                            $display("%0t: found_frame expected %h actual %h",
                                     $time, want.found_frame, rsp.found_frame);
                        if (rsp.status !== want.status)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, rsp.status);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (took_req)
                expected_q.push_back(walk_table(req.mode, req.virtual_page,
                                                req.target_frame, req.unmap));
            open_items <= open_items + int'(took_req) - int'(gave_rsp);
        end
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Page table walker testbench
// Drives queries and updates into the walker, idles both channels at random
// and leaves prediction and checking to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mptw_pkg::*;

    localparam int FRAMES = 64;
    localparam int LEVELS = 5;

    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Random part: phases of items, each opened by a register setting.
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 116;
    localparam int POOL            = 2;
    localparam int HOLD_PHASE      = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4 * LEVELS + 8;
    localparam int HISTORY_MAX     = 64;

    logic clk = 1'b0;
    logic rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int mismatch_count;
    int open_items;

    // Idle percentages per channel, set by the stimulus, read by the sender task and the receiver.
    int tx_idle_pct = 10;
    int rx_idle_pct = 78;
    // Long receiver hold-offs asked by the stimulus.
    int hold_asked  = 0;

    logic [IDX_W-1:0]   index_pool [LEVELS][POOL];
    logic [VPAGE_W-1:0] mapped_pages [$];

    mptw_req_if req_ch ();
    mptw_rsp_if rsp_ch ();

    multilevel_page_table_walker #(
        .FRAMES (FRAMES),
        .LEVELS (LEVELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    page_walk_checker #(
        .FRAMES (FRAMES),
        .LEVELS (LEVELS)
    ) walk_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .open_items     (open_items)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop; the reset sweep of the store alone zeroes FRAMES*512 entries.
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: drop ready at random, and on request hold it low for a long
    // stretch so the output register fills and the walker stalls its input.
    initial
    begin : receiver
        int served;
        served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != served)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                served++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one item, idling first at the sender's rate, and hold it until
    // the walker takes it. Valid stays high on return so a back-to-back item
    // needs no second assignment in the same step.
    task automatic send_item(
        input logic                md,
        input logic [VPAGE_W-1:0]  vp,
        input logic [FRAME_NW-1:0] tgt,
        input logic                um
    );
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= md;
        req_ch.virtual_page <= vp;
        req_ch.target_frame <= tgt;
        req_ch.unmap        <= um;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every accepted item has its response.
    // The first edge lets the checker count an item taken in this step.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_items != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly indices from a small per-level pool so that walks share tables
    // and reach the leaf level; now and then a fully random index.
    function automatic logic [VPAGE_W-1:0] pick_page();
        logic [VPAGE_W-1:0] vp;
        for (int k = 0; k < LEVELS; k++)
        begin
            if ($urandom_range(99) < 80)
                vp[IDX_W*(LEVELS-1-k) +: IDX_W] = index_pool[k][$urandom_range(POOL-1)];
            else
                vp[IDX_W*(LEVELS-1-k) +: IDX_W] = IDX_W'($urandom);
        end
        return vp;
    endfunction

    // Small targets matter: once a leaf table is reused as an inner table,
    // they act as table pointers; just-past-the-store ones give out-of-store.
    function automatic logic [FRAME_NW-1:0] pick_target();
        case ($urandom_range(3))
            0:       return FRAME_NW'($urandom_range(FRAMES - 1));
            1:       return FRAME_NW'($urandom_range(FRAMES, FRAMES + 63));
            default: return FRAME_NW'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [VPAGE_W-1:0] pick_mapped_or_fresh(input int pct_mapped);
        if (mapped_pages.size() != 0 && $urandom_range(99) < pct_mapped)
            return mapped_pages[$urandom_range(mapped_pages.size() - 1)];
        return pick_page();
    endfunction

    initial
    begin : stimulus
        logic [VPAGE_W-1:0]  all_ones_page;
        logic [VPAGE_W-1:0]  checker_page;
        logic [FRAME_NW-1:0] max_frame;
        logic [FRAME_NW-1:0] checker_frame;
        logic [VPAGE_W-1:0]  vp;
        int                  roll;

        all_ones_page = '1;
        max_frame     = '1;
        checker_page  = VPAGE_W'({VPAGE_W/2 + 1{2'b01}});
        checker_frame = {FRAME_NW/2{2'b01}};

        // Known values everywhere from time zero.
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_ROOT_FRAME;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_QUERY;
        req_ch.virtual_page  <= '0;
        req_ch.target_frame  <= '0;
        req_ch.unmap         <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers are taken during the store sweep; requests wait for it.
        write_reg(CFG_ROOT_FRAME, CFG_W'(0));
        write_reg(CFG_FIRST_FREE, CFG_W'(1));

        // Directed: empty store, then build and tear down a few paths.
        // With root 0 and the allocator at 1, the path of page 0 takes
        // frames 1..4, so frame 4 holds its leaf table.
        send_item(MODE_QUERY,  '0,            '0,        1'b0);
        send_item(MODE_QUERY,  all_ones_page, max_frame, 1'b1);
        // unmap on a missing path writes nothing
        send_item(MODE_UPDATE, '0,            '0,        1'b1);
        send_item(MODE_UPDATE, '0,            '0,        1'b0);
        send_item(MODE_QUERY,  '0,            max_frame, 1'b0);
        send_item(MODE_UPDATE, all_ones_page, max_frame, 1'b0);
        send_item(MODE_QUERY,  all_ones_page, '0,        1'b0);
        send_item(MODE_UPDATE, '0,            FRAME_NW'(100), 1'b0);
        // present path, invalid leaf: query misses, unmap still succeeds
        send_item(MODE_QUERY,  VPAGE_W'(1),   '0,        1'b0);
        send_item(MODE_UPDATE, VPAGE_W'(1),   '0,        1'b1);
        send_item(MODE_UPDATE, checker_page,  checker_frame, 1'b0);
        send_item(MODE_QUERY,  checker_page,  '0,        1'b0);
        send_item(MODE_UPDATE, all_ones_page, '0,        1'b1);
        send_item(MODE_QUERY,  all_ones_page, '0,        1'b0);
        drain();

        // Root on the leaf table: its entry for page 0 now reads as a
        // pointer to frame 100, outside the store.
        write_reg(CFG_ROOT_FRAME, CFG_W'(4));
        send_item(MODE_QUERY,  '0, '0,           1'b0);
        send_item(MODE_UPDATE, '0, FRAME_NW'(5), 1'b0);
        drain();

        // Empty top table and an allocator that is already spent.
        write_reg(CFG_ROOT_FRAME, CFG_W'(FRAMES - 1));
        write_reg(CFG_FIRST_FREE, CFG_W'(FRAMES));
        send_item(MODE_UPDATE, VPAGE_W'(45'h0_2468_ACE1_357), max_frame, 1'b0);
        send_item(MODE_QUERY,  VPAGE_W'(45'h0_2468_ACE1_357), '0,        1'b0);
        drain();

        // Two frames left: the walk runs dry halfway, partial tables stay.
        write_reg(CFG_FIRST_FREE, CFG_W'(FRAMES - 2));
        send_item(MODE_UPDATE, VPAGE_W'(45'h1_2345_6789_ABC), FRAME_NW'(7), 1'b0);
        send_item(MODE_UPDATE, VPAGE_W'(45'h1_2345_6789_ABC), FRAME_NW'(7), 1'b1);
        drain();

        // Allocator starting at frame 0 hands out the root table itself.
        write_reg(CFG_ROOT_FRAME, CFG_W'(0));
        write_reg(CFG_FIRST_FREE, CFG_W'(0));
        send_item(MODE_UPDATE, VPAGE_W'(45'h0_0A00_0000_001), FRAME_NW'(9), 1'b0);
        send_item(MODE_QUERY,  VPAGE_W'(45'h0_0A00_0000_001), '0,           1'b0);

        // Random phases: first sender light and receiver heavy idling, then
        // the other way round, then none.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            if (ph < 3)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 78;
            end
            else if (ph < 6)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 10;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // Mostly root 0; the allocator starts at 1 in the first phase, later at a
            // random frame or spent, so that frames are reused or none are left.
            if ($urandom_range(99) < 70)
                write_reg(CFG_ROOT_FRAME, CFG_W'(0));
            else
                write_reg(CFG_ROOT_FRAME, CFG_W'($urandom_range(FRAMES - 1)));
            if (ph == 0)
                write_reg(CFG_FIRST_FREE, CFG_W'(1));
            else if ($urandom_range(99) < 15)
                write_reg(CFG_FIRST_FREE, CFG_W'(FRAMES));
            else
                write_reg(CFG_FIRST_FREE, CFG_W'($urandom_range(FRAMES)));

            for (int k = 0; k < LEVELS; k++)
                for (int j = 0; j < POOL; j++)
                    index_pool[k][j] = IDX_W'($urandom);
            mapped_pages.delete();

            if (ph == HOLD_PHASE)
                hold_asked++;

            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                begin
                    // query: mostly pages mapped before; unmap and target
                    // bits are noise here
                    vp = pick_mapped_or_fresh(60);
                    send_item(MODE_QUERY, vp, FRAME_NW'({$urandom, $urandom}),
                              1'($urandom));
                end
                else if (roll < 85)
                begin
                    vp = pick_page();
                    send_item(MODE_UPDATE, vp, pick_target(), 1'b0);
                    mapped_pages.push_back(vp);
                    if (mapped_pages.size() > HISTORY_MAX)
                        void'(mapped_pages.pop_front());
                end
                else
                begin
                    vp = pick_mapped_or_fresh(70);
                    send_item(MODE_UPDATE, vp, FRAME_NW'({$urandom, $urandom}), 1'b1);
                end
            end
        end

        // Let the last responses out, give the walker its latency, decide.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && open_items == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
